// ===== design/wbps_pkg.sv =====
package wbps_pkg;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int POS_W       = 33;
  localparam int MATCH_IDX_W = 32;
  localparam int ADDR_W      = 64;
  localparam int LEN_W       = 5;
  localparam int PAT_BYTES   = 16;

  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [MATCH_IDX_W-1:0] match_idx_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [7:0]             byte_t;

  localparam cfg_idx_t REG_PAT_LOW  = 4'd0;
  localparam cfg_idx_t REG_PAT_HIGH = 4'd1;
  localparam cfg_idx_t REG_PAT_LEN  = 4'd2;
  localparam cfg_idx_t REG_WILDCARD = 4'd3;
  localparam cfg_idx_t REG_OFFSET   = 4'd4;
  localparam cfg_idx_t REG_BASE     = 4'd5;
  localparam cfg_idx_t REG_SIZE     = 4'd6;
  localparam cfg_idx_t REG_REVERSE  = 4'd7;

endpackage

// ===== design/wildcard_byte_pattern_search.sv =====
// Streams the bytes of one memory region, one request per cycle in address order while
// in_ready is high, and compares a window of the most recent bytes against a pattern of up
// to MAX_PATTERN_BYTES bytes, where the configured wildcard value matches any byte. A
// region gives exactly one result: a found result at the first full match (the rest of the
// region is dropped), or a not-found result with zero index and address at the byte flagged
// last. The window compare runs in the cycle a byte is taken, its outcome is registered in
// stage one, and the index and address are formed from that stage into the output register;
// a stalled result does not stop the input until both stages are full. The user must write
// configuration only while no request is in flight; the block itself does not enforce it.
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_idx_t   cfg_index,
  input  cfg_data_t  cfg_data,

  input  logic       in_valid,
  output logic       in_ready,
  input  byte_t      in_data_byte,
  input  logic       in_last_byte,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output match_idx_t out_match_index,
  output addr_t      out_match_address
);

  localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int DIFF_W    = ((WIN_IDX_W > LEN_W) ? WIN_IDX_W : LEN_W) + 1;

  logic [63:0] pat_low_r;
  logic [63:0] pat_high_r;
  len_t        pat_len_r;
  byte_t       wildcard_r;
  logic [31:0] offset_r;
  addr_t       base_r;
  logic [31:0] size_r;
  logic        reverse_r;

  byte_t       win_r   [MAX_PATTERN_BYTES];
  byte_t       win_nxt [MAX_PATTERN_BYTES];
  pos_t        pos_r;
  logic        done_r;

  logic        s1_valid_r;
  logic        s1_found_r;
  match_idx_t  s1_start_r;

  logic        out_valid_r;
  logic        out_found_r;
  match_idx_t  out_index_r;
  addr_t       out_addr_r;

  logic        in_acc;
  logic        out_adv;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic        len_ok;
  logic        hit;
  logic        emit;
  match_idx_t  start;
  logic [127:0] pat_all;

  match_idx_t  rev_index;
  match_idx_t  res_index;
  addr_t       res_addr;
  addr_t       offset_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      wildcard_r <= '0;
      offset_r   <= '0;
      base_r     <= '0;
      size_r     <= '0;
      reverse_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        REG_WILDCARD: wildcard_r <= cfg_data[7:0];
        REG_OFFSET:   offset_r   <= cfg_data[31:0];
        REG_BASE:     base_r     <= cfg_data;
        REG_SIZE:     size_r     <= cfg_data[31:0];
        REG_REVERSE:  reverse_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_acc   = in_valid && in_ready;
  assign pat_all  = {pat_high_r, pat_low_r};

  always_comb begin
    win_nxt[0] = in_data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  // Pattern byte j lines up with the window byte that arrived len-1-j requests ago.
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cmp
    byte_t             pat_b;
    logic [DIFF_W-1:0] diff;
    logic              in_use;
    if (j < PAT_BYTES) begin : g_pat
      assign pat_b = pat_all[8*j +: 8];
    end else begin : g_zero
      assign pat_b = 8'h00;
    end
    assign diff    = DIFF_W'(pat_len_r) - DIFF_W'(1) - DIFF_W'(j);
    assign in_use  = DIFF_W'(j) < DIFF_W'(pat_len_r);
    assign byte_ok[j] = !in_use || (pat_b == wildcard_r) ||
                        (pat_b == win_nxt[diff[WIN_IDX_W-1:0]]);
  end

  assign len_ok = (pat_len_r != '0) &&
                  ({27'd0, pat_len_r} <= 32'(MAX_PATTERN_BYTES)) &&
                  ({27'd0, pat_len_r} <= size_r) &&
                  (pos_r < {1'b0, size_r}) &&
                  (({1'b0, pos_r} + 34'd1) >= 34'(pat_len_r));
  assign hit   = !done_r && len_ok && (&byte_ok);
  assign emit  = hit || (in_last_byte && !done_r);
  assign start = MATCH_IDX_W'(pos_r + POS_W'(1) - POS_W'(pat_len_r));

  always_ff @(posedge clk) begin
    if (in_acc && !done_r) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      done_r <= 1'b0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        pos_r  <= '0;
        done_r <= 1'b0;
      end else if (!done_r) begin
        if (pos_r != '1) begin
          pos_r <= pos_r + POS_W'(1);
        end
        done_r <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= emit;
    end else if (out_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_found_r <= hit;
      s1_start_r <= start;
    end
  end

  assign offset_ext = {{32{offset_r[31]}}, offset_r};
  assign rev_index  = size_r - s1_start_r;

  always_comb begin
    if (!s1_found_r) begin
      res_index = '0;
      res_addr  = '0;
    end else if (reverse_r) begin
      res_index = rev_index;
      res_addr  = base_r - ADDR_W'(rev_index) - offset_ext;
    end else begin
      res_index = s1_start_r;
      res_addr  = base_r + ADDR_W'(s1_start_r) + offset_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_found_r <= s1_found_r;
      out_index_r <= res_index;
      out_addr_r  <= res_addr;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_index   = out_index_r;
  assign out_match_address = out_addr_r;

endmodule

// ===== design/wbps_checker.sv =====
module wbps_checker
  import wbps_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input match_idx_t out_match_index,
  input addr_t      out_match_address
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A not-found result carries a zero index and a zero address.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_match_index == '0) && (out_match_address == '0))
    else $error("not-found result with nonzero index or address");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // A newly offered result traces back to an accepted input byte, through the stage-one and output registers.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching input request");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);

// ===== tb/sv/tb.sv =====
module tb;
  import wbps_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REGION_MAX    = 40;

  typedef struct packed {
    logic       found;
    match_idx_t match_index;
    addr_t      match_address;
  } search_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = '0;
  cfg_data_t  cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  byte_t      in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_found;
  match_idx_t out_match_index;
  addr_t      out_match_address;

  // Shadow copy of the search registers.
  cfg_data_t   cfg_low = '0;
  cfg_data_t   cfg_high = '0;
  len_t        cfg_len = '0;
  byte_t       cfg_wild = '0;
  logic [31:0] cfg_offset = '0;
  addr_t       cfg_base = '0;
  logic [31:0] cfg_size = '0;
  logic        cfg_reverse = 1'b0;

  // Scan state for the region in progress.
  byte_t window [PAT_BYTES];
  pos_t  scan_pos = '0;
  logic  region_matched = 1'b0;

  search_result_t results_due [$];

  int send_idle_pct = 38;
  int recv_idle_pct = 52;
  int error_count = 0;
  int stall_cycles = 0;

  wildcard_byte_pattern_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_index  (out_match_index),
    .out_match_address(out_match_address)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic byte_t pattern_byte(input int j);
    if (j < 8) return cfg_low[8*j +: 8];
    return cfg_high[8*(j-8) +: 8];
  endfunction

  function automatic byte_t pick_byte();
    byte_t choices [4];
    choices = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    if ($urandom_range(99) < 30) return byte_t'($urandom_range(255));
    return choices[$urandom_range(3)];
  endfunction

  task automatic clear_scan();
    foreach (window[i]) window[i] = '0;
    scan_pos = '0;
    region_matched = 1'b0;
  endtask

  task automatic scan_byte(input byte_t d, input logic last);
    logic [63:0]    pos;
    logic [63:0]    start;
    logic [63:0]    idx;
    logic [63:0]    ofs64;
    logic           hit;
    search_result_t r;
    if (!region_matched) begin
      pos = 64'(scan_pos);
      for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = d;
      if (scan_pos != '1) scan_pos = scan_pos + pos_t'(1);
      if (cfg_len != '0 && int'(cfg_len) <= PAT_BYTES && 32'(cfg_len) <= cfg_size &&
          pos < 64'(cfg_size) && pos + 64'd1 >= 64'(cfg_len)) begin
        hit = 1'b1;
        for (int j = 0; j < int'(cfg_len); j++) begin
          if (pattern_byte(j) != cfg_wild && pattern_byte(j) != window[int'(cfg_len) - 1 - j])
            hit = 1'b0;
        end
        if (hit) begin
          start = pos + 64'd1 - 64'(cfg_len);
          ofs64 = {{32{cfg_offset[31]}}, cfg_offset};
          if (cfg_reverse) begin
            idx = 64'(cfg_size) - start;
            r.match_address = cfg_base - idx - ofs64;
          end else begin
            idx = start;
            r.match_address = cfg_base + start + ofs64;
          end
          r.found = 1'b1;
          r.match_index = idx[31:0];
          results_due.push_back(r);
          region_matched = 1'b1;
        end
      end
    end
    if (last) begin
      if (!region_matched) begin
        r = '0;
        results_due.push_back(r);
      end
      clear_scan();
    end
  endtask

  task automatic send_byte(input byte_t d, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(d, last);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAT_LOW:  cfg_low = val;
      REG_PAT_HIGH: cfg_high = val;
      REG_PAT_LEN:  cfg_len = val[LEN_W-1:0];
      REG_WILDCARD: cfg_wild = val[7:0];
      REG_OFFSET:   cfg_offset = val[31:0];
      REG_BASE:     cfg_base = val;
      REG_SIZE:     cfg_size = val[31:0];
      REG_REVERSE:  cfg_reverse = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_search(input cfg_data_t low, input cfg_data_t high, input len_t len,
                            input byte_t wild, input logic [31:0] ofs, input addr_t base,
                            input logic [31:0] size, input logic rev);
    drain();
    write_reg(REG_PAT_LOW, low);
    write_reg(REG_PAT_HIGH, high);
    write_reg(REG_PAT_LEN, cfg_data_t'(len));
    write_reg(REG_WILDCARD, cfg_data_t'(wild));
    write_reg(REG_OFFSET, cfg_data_t'(ofs));
    write_reg(REG_BASE, base);
    write_reg(REG_SIZE, cfg_data_t'(size));
    write_reg(REG_REVERSE, cfg_data_t'(rev));
  endtask

  task automatic test_reset_defaults();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_forward_wildcard();
    set_search(64'h0000_0000_44EE_2211, '1, 5'd4, 8'hEE, 32'h8000_0000,
               64'hFFFF_FFFF_FFFF_FFF0, 32'd8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_reverse_last_byte();
    set_search(64'h0000_0000_0000_2211, '0, 5'd2, 8'h00, 32'h7FFF_FFFF,
               64'h0, 32'd5, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
  endtask

  task automatic test_window_bounds();
    set_search(64'h0000_0000_00EE_2211, '0, 5'd3, 8'h11, 32'h0,
               64'h1000, 32'd4, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'hFF, 1'b1);
    set_search('0, '0, 5'd5, 8'h00, 32'h0, 64'h1000, 32'd4, 1'b0);
    for (int k = 0; k < 4; k++) send_byte(byte_t'($urandom_range(255)), k == 3);
  endtask

  task automatic random_setup();
    cfg_data_t   lo;
    cfg_data_t   hi;
    len_t        len;
    byte_t       wild;
    logic [31:0] ofs;
    addr_t       base;
    logic [31:0] size;
    int          r;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pick_byte();
      hi[8*k +: 8] = pick_byte();
    end
    r = $urandom_range(99);
    if (r < 5) len = '0;
    else if (r < 12) len = 5'd16;
    else if (r < 16) len = len_t'($urandom_range(31, 17));
    else if (r < 25) len = len_t'($urandom_range(15, 9));
    else len = len_t'($urandom_range(8, 1));
    if ($urandom_range(1)) wild = lo[8*$urandom_range(7) +: 8];
    else wild = pick_byte();
    case ($urandom_range(9))
      0: ofs = 32'h8000_0000;
      1: ofs = 32'h7FFF_FFFF;
      2: ofs = '0;
      default: ofs = $urandom;
    endcase
    case ($urandom_range(5))
      0: base = '0;
      1: base = '1;
      default: base = {$urandom, $urandom};
    endcase
    r = $urandom_range(99);
    if (r < 5) size = '0;
    else if (r < 10) size = '1;
    else if (r < 20) size = 32'(len);
    else size = $urandom_range(REGION_MAX, 1);
    set_search(lo, hi, len, wild, ofs, base, size, 1'($urandom_range(1)));
  endtask

  task automatic test_random_regions(input int n_items);
    int    sent;
    int    regions;
    int    n;
    int    s;
    int    r;
    bit    plant;
    byte_t b;
    sent = 0;
    regions = 0;
    while (sent < n_items) begin
      if (regions % 3 == 0) random_setup();
      r = $urandom_range(99);
      if (cfg_size == 0 || cfg_size > REGION_MAX) n = $urandom_range(REGION_MAX, 1);
      else if (r < 15) n = int'(cfg_size) + $urandom_range(6, 1);
      else if (r < 25) n = $urandom_range(int'(cfg_size), 1);
      else n = int'(cfg_size);
      plant = ($urandom_range(99) < 60) && cfg_len != '0 && int'(cfg_len) <= PAT_BYTES &&
              int'(cfg_len) <= n;
      s = plant ? $urandom_range(n - int'(cfg_len)) : 0;
      for (int k = 0; k < n; k++) begin
        if (plant && k >= s && k < s + int'(cfg_len) && pattern_byte(k - s) != cfg_wild)
          b = pattern_byte(k - s);
        else
          b = pick_byte();
        send_byte(b, k == n - 1);
      end
      sent += n;
      regions++;
    end
  endtask

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: found=%0b index=%0d address=%h",
                   out_found, out_match_index, out_match_address);
      end else begin
        want = results_due.pop_front();
        if (out_found !== want.found || out_match_index !== want.match_index ||
            out_match_address !== want.match_address) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected found=%0b index=%0d address=%h, got %0b %0d %h",
                     want.found, want.match_index, want.match_address,
                     out_found, out_match_index, out_match_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_scan();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_forward_wildcard();
    test_reverse_last_byte();
    test_window_bounds();
    test_random_regions(650);

    send_idle_pct = 52;
    recv_idle_pct = 38;
    test_random_regions(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_regions(650);

    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
